>>> rtl/tft_pkg.sv
// Package for the TCP flow table: slot layout, codes, FSM state and
// controller/datapath command and status bundles. No dependencies.
package tft_pkg;

	// Folded tuple sum is 17 bits wide; reciprocal product is twice that
	localparam int HASH_W = 17;
	localparam int PROD_W = 2 * HASH_W;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_SET    = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_DUP  = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_MOD,
		S_READ,
		S_EVAL
	} state_t;

	// One way of a bucket
	typedef struct packed {
		logic        valid;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] size;
		logic [31:0] seq;
	} slot_t;

	// Controller -> datapath
	typedef struct packed {
		logic ld;    // capture input word
		logic hash;  // fold + reciprocal multiply
		logic mod;   // remainder -> bucket index
		logic rd;    // bucket row read
		logic eval;  // compare, write back, load result
		logic clr;   // clearing pass, one row
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic clr_last;
	} sts_t;

endpackage

>>> rtl/tft_ctrl.sv
// Controller for the TCP flow table: sequencer FSM, input/output handshakes.
// Depends on tft_pkg.
module tft_ctrl import tft_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nxt;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.eval) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.ld    = 1'b1;
					state_nxt = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash  = 1'b1;
				state_nxt = S_MOD;
			end
			S_MOD: begin
				cmd.mod   = 1'b1;
				state_nxt = S_READ;
			end
			S_READ: begin
				cmd.rd    = 1'b1;
				state_nxt = S_EVAL;
			end
			S_EVAL: begin
				// result register must be free (or draining) before it is reloaded
				if (!out_valid_q || m_tready) begin
					cmd.eval = 1'b1;
					s_tready = 1'b1;
					if (s_tvalid) begin
						cmd.ld    = 1'b1;
						state_nxt = S_HASH;
					end else begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

>>> rtl/tft_dp.sv
// Datapath for the TCP flow table: input capture, bucket hash, bucket row
// memory, way compare and result register. Depends on tft_pkg.
module tft_dp import tft_pkg::*; #(
	parameter int NUM_BUCKETS = 128,
	parameter int WAYS        = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	output sts_t         sts,
	input  logic [1:0]   in_opcode,
	input  logic [159:0] in_data,
	output logic [1:0]   out_status,
	output logic [63:0]  out_data
);

	localparam int BKT_W = $clog2(NUM_BUCKETS);
	// floor(2^17 / N): quotient estimate is low by at most one
	localparam int RECIP = (1 << HASH_W) / NUM_BUCKETS;

	typedef slot_t [WAYS-1:0] row_t;

	row_t mem_q [NUM_BUCKETS];

	opcode_t     op_q;
	logic [31:0] sip_q, dip_q, seq_q, size_q;
	logic [15:0] sp_q, dp_q;

	logic [HASH_W-1:0] sum_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [BKT_W-1:0]  bucket_s2;
	row_t              rd_row_s3;
	logic [BKT_W-1:0]  clr_cnt_q;

	logic [1:0]  status_q;
	logic [31:0] o_size_q, o_seq_q;

	// ---- hash fold ----
	logic [16:0]       p_sum, p_fold, a_fold;
	logic [31:0]       a_sum;
	logic [17:0]       s_sum;
	logic [HASH_W-1:0] s_fold;

	always_comb begin
		p_sum  = {1'b0, sp_q} + {1'b0, dp_q};
		p_fold = {16'b0, p_sum[16]} + {1'b0, p_sum[15:0]};
		a_sum  = sip_q + dip_q;
		a_fold = {1'b0, a_sum[31:16]} + {1'b0, a_sum[15:0]};
		s_sum  = {1'b0, p_fold} + {1'b0, a_fold};
		s_fold = {15'b0, s_sum[17:16]} + {1'b0, s_sum[15:0]};
	end

	// ---- remainder with one correction ----
	logic [HASH_W-1:0] quo, qn, rem;
	logic [HASH_W-1:0] bucket;

	always_comb begin
		quo = prod_s1[PROD_W-1:HASH_W];
		qn  = quo * HASH_W'(NUM_BUCKETS);
		rem = sum_s1 - qn;
		if (rem >= HASH_W'(NUM_BUCKETS)) begin
			bucket = rem - HASH_W'(NUM_BUCKETS);
		end else begin
			bucket = rem;
		end
	end

	// ---- way compare and update ----
	logic [WAYS-1:0] hit_v, free_v, hit_oh, free_oh;
	logic            hit_any, free_any;
	logic [31:0]     hit_size, hit_seq;
	row_t            upd_row, wr_row;
	logic            upd;
	status_t         status_nxt;
	logic [31:0]     size_nxt, seq_nxt;
	logic            wr_en;
	logic [BKT_W-1:0] wr_addr;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			hit_v[w] = rd_row_s3[w].valid && (
				(rd_row_s3[w].src_ip == sip_q && rd_row_s3[w].dst_ip == dip_q &&
				 rd_row_s3[w].src_port == sp_q && rd_row_s3[w].dst_port == dp_q) ||
				(rd_row_s3[w].src_ip == dip_q && rd_row_s3[w].dst_ip == sip_q &&
				 rd_row_s3[w].src_port == dp_q && rd_row_s3[w].dst_port == sp_q));
			free_v[w] = !rd_row_s3[w].valid;
		end
		// lowest set bit
		hit_oh   = hit_v & (~hit_v + WAYS'(1));
		free_oh  = free_v & (~free_v + WAYS'(1));
		hit_any  = |hit_v;
		free_any = |free_v;
		hit_size = '0;
		hit_seq  = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (hit_oh[w]) begin
				hit_size = hit_size | rd_row_s3[w].size;
				hit_seq  = hit_seq | rd_row_s3[w].seq;
			end
		end

		upd        = 1'b0;
		upd_row    = rd_row_s3;
		status_nxt = ST_MISS;
		size_nxt   = '0;
		seq_nxt    = '0;
		case (op_q)
			OP_INSERT: begin
				if (hit_any) begin
					status_nxt = ST_DUP;
				end else if (!free_any) begin
					status_nxt = ST_FULL;
				end else begin
					status_nxt = ST_OK;
					upd        = 1'b1;
					for (int w = 0; w < WAYS; w++) begin
						if (free_oh[w]) begin
							upd_row[w] = '{valid: 1'b1, src_ip: sip_q, dst_ip: dip_q,
								src_port: sp_q, dst_port: dp_q, size: 32'd0, seq: 32'd0};
						end
					end
				end
			end
			OP_LOOKUP: begin
				if (hit_any) begin
					status_nxt = ST_OK;
					size_nxt   = hit_size;
					seq_nxt    = hit_seq;
				end
			end
			OP_SET: begin
				if (hit_any) begin
					status_nxt = ST_OK;
					size_nxt   = size_q;
					seq_nxt    = seq_q;
					upd        = 1'b1;
					for (int w = 0; w < WAYS; w++) begin
						if (hit_oh[w]) begin
							upd_row[w].size = size_q;
							upd_row[w].seq  = seq_q;
						end
					end
				end
			end
			default: begin
				status_nxt = ST_MISS;
			end
		endcase

		wr_en   = cmd.clr | (cmd.eval & upd);
		wr_addr = cmd.clr ? clr_cnt_q : bucket_s2;
		wr_row  = cmd.clr ? row_t'('0) : upd_row;
	end

	// ---- control state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + BKT_W'(1);
		end
	end

	assign sts.clr_last = (clr_cnt_q == BKT_W'(NUM_BUCKETS - 1));

	// ---- payload registers and memory ----
	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			op_q   <= opcode_t'(in_opcode);
			sip_q  <= in_data[31:0];
			dip_q  <= in_data[63:32];
			sp_q   <= in_data[79:64];
			dp_q   <= in_data[95:80];
			seq_q  <= in_data[127:96];
			size_q <= in_data[159:128];
		end
		if (cmd.hash) begin
			sum_s1  <= s_fold;
			prod_s1 <= PROD_W'(s_fold) * PROD_W'(RECIP);
		end
		if (cmd.mod) begin
			bucket_s2 <= bucket[BKT_W-1:0];
		end
		if (cmd.rd) begin
			rd_row_s3 <= mem_q[bucket_s2];
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_row;
		end
		if (cmd.eval) begin
			status_q <= status_nxt;
			o_size_q <= size_nxt;
			o_seq_q  <= seq_nxt;
		end
	end

	assign out_status = status_q;
	assign out_data   = {o_seq_q, o_size_q};

endmodule

>>> rtl/tcp_flow_table_unit.sv
// Top level of the TCP flow table: controller plus datapath.
// Depends on tft_pkg, tft_ctrl, tft_dp.
//
// Usage:
//  - Input channel s_axis_*: one word per packet. tuser carries the opcode
//    (insert, look up, set size/sequence); tdata carries the four-tuple,
//    the sequence and the data size.
//  - Output channel m_axis_*: exactly one result word per input word, in
//    order. tuser carries the status, tdata the stored size and sequence
//    (both zero on a miss, a refused insert or an unused opcode).
//  - A tuple matches a stored flow in either direction. Buckets hold WAYS
//    slots; the bucket index is the end-around fold of the tuple sums,
//    reduced modulo NUM_BUCKETS by a reciprocal multiply and one correction.
//  - An accepted word passes the hash, modulo, read and compare states in
//    turn; these stages and the read-compare-write of the single bucket
//    row memory keep one word in work at a time. The next word is
//    accepted in the same cycle a result is loaded.
//  - Reset: after arst_n releases, a clearing pass of NUM_BUCKETS cycles
//    invalidates every bucket row; s_axis_tready stays low until it ends.
//  - Stall: a held result waits in the output register; one more word is
//    taken and worked up to the compare, then input stalls until m_axis_tready.
module tcp_flow_table_unit import tft_pkg::*; #(
	parameter int NUM_BUCKETS = 128,
	parameter int WAYS        = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: src_ip[31:0], dst_ip[63:32], src_port[79:64], dst_port[95:80],
	//        tcp_seq[127:96], data_size[159:128]
	input  logic [159:0] s_axis_tdata,
	// tuser: opcode[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: stored_size[31:0], stored_seq[63:32]
	output logic [63:0]  m_axis_tdata,
	// tuser: status[1:0]
	output logic [1:0]   m_axis_tuser
);

	cmd_t cmd;
	sts_t sts;

	tft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tft_dp #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.WAYS        (WAYS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_opcode  (s_axis_tuser),
		.in_data    (s_axis_tdata),
		.out_status (m_axis_tuser),
		.out_data   (m_axis_tdata)
	);

endmodule

>>> verif/tcp_flow_table_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for tcp_flow_table_unit: directed then random packet words, checked
// against a flow-table predictor of its own. Depends on tft_pkg and the RTL top level.
module tcp_flow_table_unit_test;
	import tft_pkg::*;

	localparam int NUM_BUCKETS = 128;
	localparam int WAYS = 4;
	localparam int SLOTS = NUM_BUCKETS * WAYS;
	localparam logic [31:0] HALF_MASK = 32'h0000_ffff;
	localparam logic [1:0] OP_UNUSED = 2'd3;  // no-op opcode, answers as a miss
	localparam int RANDOM_WORDS = 1900;
	localparam int CROWD_BUCKETS = 8;         // hot buckets, so full and duplicate come up often
	localparam int DRAIN_CYCLES = 24;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [31:0] seq;
		logic [31:0] size;
	} flow_pkt_t;

	typedef struct {
		status_t     status;
		logic [31:0] size;
		logic [31:0] seq;
	} flow_reply_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [159:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	// Flow table as the block should hold it
	bit          flow_live[SLOTS];
	logic [31:0] flow_sip[SLOTS];
	logic [31:0] flow_dip[SLOTS];
	logic [15:0] flow_sp[SLOTS];
	logic [15:0] flow_dp[SLOTS];
	logic [31:0] flow_size[SLOTS];
	logic [31:0] flow_seq[SLOTS];

	flow_pkt_t   words_to_send[$];
	flow_reply_t replies_due[$];
	flow_pkt_t   in_flight;
	int unsigned send_wait = 0;
	int unsigned hold_wait = 0;
	bit          tx_quiet = 1'b0;
	bit          rx_quiet = 1'b0;
	int unsigned fault_count = 0;

	tcp_flow_table_unit #(
		.NUM_BUCKETS(NUM_BUCKETS),
		.WAYS(WAYS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// End-around fold of port sum plus address sum, then modulo the bucket count
	function automatic int unsigned flow_bucket(flow_pkt_t p);
		logic [31:0] ps, as, s;
		ps = {16'd0, p.sp} + {16'd0, p.dp};
		ps = (ps >> 16) + (ps & HALF_MASK);
		as = p.sip + p.dip;
		as = (as >> 16) + (as & HALF_MASK);
		s = ps + as;
		s = (s >> 16) + (s & HALF_MASK);
		return s % NUM_BUCKETS;
	endfunction

	// Stored flow matches the tuple as sent or with both ends swapped
	function automatic bit same_flow(int unsigned slot, flow_pkt_t p);
		bit fwd, rev;
		fwd = flow_sip[slot] == p.sip && flow_dip[slot] == p.dip &&
		      flow_sp[slot] == p.sp && flow_dp[slot] == p.dp;
		rev = flow_sip[slot] == p.dip && flow_dip[slot] == p.sip &&
		      flow_sp[slot] == p.dp && flow_dp[slot] == p.sp;
		return fwd || rev;
	endfunction

	// Applies one packet word to the table and returns the reply it should cause
	function automatic flow_reply_t predict_reply(flow_pkt_t p);
		int unsigned base;
		int hit, free_slot;
		flow_reply_t r;
		base = flow_bucket(p) * WAYS;
		hit = -1;
		free_slot = -1;
		r.status = ST_MISS;
		r.size = '0;
		r.seq = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (flow_live[base + w]) begin
				if (hit < 0 && same_flow(base + w, p))
					hit = base + w;
			end else if (free_slot < 0) begin
				free_slot = base + w;
			end
		end
		case (p.op)
			OP_INSERT: begin
				if (hit >= 0) begin
					r.status = ST_DUP;
				end else if (free_slot < 0) begin
					r.status = ST_FULL;
				end else begin
					flow_live[free_slot] = 1'b1;
					flow_sip[free_slot] = p.sip;
					flow_dip[free_slot] = p.dip;
					flow_sp[free_slot] = p.sp;
					flow_dp[free_slot] = p.dp;
					flow_size[free_slot] = '0;
					flow_seq[free_slot] = '0;
					r.status = ST_OK;
				end
			end
			OP_LOOKUP: begin
				if (hit >= 0) begin
					r.status = ST_OK;
					r.size = flow_size[hit];
					r.seq = flow_seq[hit];
				end
			end
			OP_SET: begin
				if (hit >= 0) begin
					flow_size[hit] = p.size;
					flow_seq[hit] = p.seq;
					r.status = ST_OK;
					r.size = p.size;
					r.seq = p.seq;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic flow_pkt_t make_pkt(logic [1:0] op, logic [31:0] sip, logic [31:0] dip,
			logic [15:0] sp, logic [15:0] dp, logic [31:0] seq, logic [31:0] size);
		flow_pkt_t p;
		p.op = op;
		p.sip = sip;
		p.dip = dip;
		p.sp = sp;
		p.dp = dp;
		p.seq = seq;
		p.size = size;
		return p;
	endfunction

	// Random tuple; when crowded, retried until it lands in one of the hot buckets
	function automatic flow_pkt_t fresh_tuple(bit crowded);
		flow_pkt_t p;
		do begin
			p = make_pkt(OP_LOOKUP, $urandom, $urandom, $urandom, $urandom, '0, '0);
		end while (crowded && flow_bucket(p) >= CROWD_BUCKETS);
		return p;
	endfunction

	// Per-word idle count; quiet stretches of back-to-back words come and go
	function automatic int unsigned pick_gap(inout bit quiet);
		if ($urandom_range(0, 31) == 0)
			quiet = ~quiet;
		return quiet ? 0 : $urandom_range(0, 14);
	endfunction

	// Packet word driver: prediction is taken at acceptance, in acceptance order
	always @(posedge clk or negedge arst_n) begin
		logic go;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			send_wait = 0;
		end else begin
			go = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				replies_due.push_back(predict_reply(in_flight));
				go = 1'b0;
			end
			if (!go) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (words_to_send.size() > 0) begin
					in_flight = words_to_send.pop_front();
					s_axis_tdata <= {in_flight.size, in_flight.seq, in_flight.dp,
					                 in_flight.sp, in_flight.dip, in_flight.sip};
					s_axis_tuser <= in_flight.op;
					send_wait = pick_gap(tx_quiet);
					go = 1'b1;
				end
			end
			s_axis_tvalid <= go;
		end
	end

	// Reply monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		flow_reply_t want;
		logic rdy;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_wait = 0;
		end else begin
			rdy = m_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				if (replies_due.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("unexpected reply: status %0d size %h seq %h",
						         m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]);
				end else begin
					want = replies_due.pop_front();
					if (m_axis_tuser !== want.status || m_axis_tdata[31:0] !== want.size ||
					    m_axis_tdata[63:32] !== want.seq) begin
						fault_count++;
						if (fault_count <= 10)
							$display("reply mismatch: expected status %0d size %h seq %h, got status %0d size %h seq %h",
							         want.status, want.size, want.seq, m_axis_tuser,
							         m_axis_tdata[31:0], m_axis_tdata[63:32]);
					end
				end
				hold_wait = pick_gap(rx_quiet);
				rdy = (hold_wait == 0);
			end else if (!m_axis_tready) begin
				if (hold_wait > 0)
					hold_wait--;
				rdy = (hold_wait == 0);
			end
			m_axis_tready <= rdy;
		end
	end

	initial begin
		flow_pkt_t t;
		flow_pkt_t known[$];
		int unsigned roll, pick, cyc;
		logic [1:0] op;

		// Bucket 0: all-zero addresses with ports that are multiples of the bucket count
		words_to_send.push_back(make_pkt(OP_LOOKUP, 0, 0, 0, 0, 0, 0));       // empty table
		words_to_send.push_back(make_pkt(OP_INSERT, 0, 0, 0, 0, 0, 0));
		words_to_send.push_back(make_pkt(OP_INSERT, 0, 0, 0, 0, 0, 0));       // duplicate
		words_to_send.push_back(make_pkt(OP_INSERT, 0, 0, 128, 0, 0, 0));
		words_to_send.push_back(make_pkt(OP_INSERT, 0, 0, 0, 128, 0, 0));     // reverse dup
		words_to_send.push_back(make_pkt(OP_INSERT, 0, 0, 256, 0, 0, 0));
		words_to_send.push_back(make_pkt(OP_INSERT, 0, 0, 384, 0, 0, 0));     // last way
		words_to_send.push_back(make_pkt(OP_INSERT, 0, 0, 512, 0, 0, 0));     // bucket full
		words_to_send.push_back(make_pkt(OP_LOOKUP, 0, 0, 512, 0, 0, 0));
		words_to_send.push_back(make_pkt(OP_SET, 0, 0, 512, 0, 1, 1));        // set miss
		words_to_send.push_back(make_pkt(OP_SET, 0, 0, 256, 0, '1, '1));
		words_to_send.push_back(make_pkt(OP_LOOKUP, 0, 0, 0, 256, 0, 0));     // reverse hit
		words_to_send.push_back(make_pkt(OP_SET, 0, 0, 0, 0, 0, 0));
		// All-ones tuple, largest fold sums
		words_to_send.push_back(make_pkt(OP_INSERT, '1, '1, '1, '1, 0, 0));
		words_to_send.push_back(make_pkt(OP_SET, '1, '1, '1, '1, 32'h1234_5678, 32'h9abc_def0));
		words_to_send.push_back(make_pkt(OP_UNUSED, '1, '1, '1, '1, '1, '1));
		words_to_send.push_back(make_pkt(OP_LOOKUP, '1, '1, '1, '1, 0, 0));
		words_to_send.push_back(make_pkt(OP_LOOKUP, '1, '1, '1, 16'hfffe, 0, 0));
		// Addresses swapped but ports not: a different flow
		words_to_send.push_back(make_pkt(OP_INSERT, '1, 0, '1, 0, 0, 0));
		words_to_send.push_back(make_pkt(OP_INSERT, 0, '1, '1, 0, 0, 0));
		words_to_send.push_back(make_pkt(OP_LOOKUP, 0, '1, 0, '1, 0, 0));
		words_to_send.push_back(make_pkt(OP_INSERT, 0, 0, 640, 0, 0, 0));     // still full

		// Random part: mostly known flows (either direction), some near misses and new flows
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 30)
				op = OP_INSERT;
			else if (roll < 62)
				op = OP_LOOKUP;
			else if (roll < 95)
				op = OP_SET;
			else
				op = OP_UNUSED;
			roll = $urandom_range(0, 99);
			if (known.size() == 0 || roll < (op == OP_INSERT ? 55 : 15)) begin
				t = fresh_tuple($urandom_range(0, 1));
				if (op == OP_INSERT)
					known.push_back(t);
			end else begin
				t = known[$urandom_range(0, known.size() - 1)];
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					// one bit off a known flow
					case ($urandom_range(0, 3))
						0: t.sip ^= 32'd1 << $urandom_range(0, 31);
						1: t.dip ^= 32'd1 << $urandom_range(0, 31);
						2: t.sp ^= 16'd1 << $urandom_range(0, 15);
						default: t.dp ^= 16'd1 << $urandom_range(0, 15);
					endcase
				end else if (pick < 56) begin
					t = make_pkt(op, t.dip, t.sip, t.dp, t.sp, 0, 0);
				end
			end
			t.op = op;
			t.seq = $urandom;
			t.size = $urandom;
			words_to_send.push_back(t);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		cyc = 12;
		while (!(words_to_send.size() == 0 && !s_axis_tvalid && replies_due.size() == 0) &&
		       cyc < LIMIT_CYCLES) begin
			@(negedge clk);
			cyc++;
		end
		if (cyc >= LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end else begin
			// let any stray reply show up before the verdict
			repeat (DRAIN_CYCLES) @(negedge clk);
			if (fault_count == 0)
				$display("All tests passed");
			else
				$display("Some tests failed");
			$finish;
		end
	end

endmodule

>>> files.f
rtl/tft_pkg.sv
rtl/tft_ctrl.sv
rtl/tft_dp.sv
rtl/tcp_flow_table_unit.sv
verif/tcp_flow_table_unit_test.sv
